// ===== rtl/bru_pkg.sv =====
// Package for the branch resolve unit: operation, size, condition and flag codes,
// and the request and result types shared by the execute logic and the top level.
// No dependencies.
`timescale 1ns / 1ps

package bru_pkg;

  // Operation codes.
  localparam logic [1:0] OP_ACB  = 2'd0;  // add-compare-branch
  localparam logic [1:0] OP_CASE = 2'd1;  // case dispatch
  localparam logic [1:0] OP_BCC  = 2'd2;  // conditional branch
  localparam logic [1:0] OP_NONE = 2'd3;  // undefined, does nothing

  // Operand size codes. The fourth code behaves as longword.
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;
  localparam logic [1:0] SZ_LONG = 2'd2;
  localparam logic [1:0] SZ_RSVD = 2'd3;

  // Branch condition codes.
  localparam logic [3:0] CC_NE   = 4'd0;
  localparam logic [3:0] CC_EQ   = 4'd1;
  localparam logic [3:0] CC_GT   = 4'd2;
  localparam logic [3:0] CC_LE   = 4'd3;
  localparam logic [3:0] CC_GE   = 4'd4;
  localparam logic [3:0] CC_LT   = 4'd5;
  localparam logic [3:0] CC_GTU  = 4'd6;
  localparam logic [3:0] CC_LEQU = 4'd7;
  localparam logic [3:0] CC_VC   = 4'd8;
  localparam logic [3:0] CC_VS   = 4'd9;
  localparam logic [3:0] CC_GEQU = 4'd10;
  localparam logic [3:0] CC_CS   = 4'd11;
  localparam logic [3:0] CC_LBS  = 4'd12;
  localparam logic [3:0] CC_LBC  = 4'd13;

  // Bit positions in the flag vector.
  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_V = 1;
  localparam int unsigned FLAG_C = 0;

  typedef logic [3:0] flags_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  size;
    logic [3:0]  condition;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] operand_c;
    logic [31:0] table_pc;
    logic [31:0] branch_target;
  } req_t;

  typedef struct packed {
    logic        taken;
    logic [31:0] next_pc;
    logic        table_read;
    logic        write_valid;
    logic [31:0] write_value;
    flags_t      flags_out;
  } res_t;

endpackage

// ===== rtl/bru_in_if.sv =====
// Input channel of the branch resolve unit: valid/ready handshake and the
// fields of one branch instruction. No dependencies.
`timescale 1ns / 1ps

interface bru_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  size;
  logic [3:0]  condition;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  logic [31:0] operand_c;
  logic [31:0] table_pc;
  logic [31:0] branch_target;

  modport source (
    output valid, operation, size, condition, operand_a, operand_b, operand_c,
           table_pc, branch_target,
    input  ready
  );

  modport sink (
    input  valid, operation, size, condition, operand_a, operand_b, operand_c,
           table_pc, branch_target,
    output ready
  );
endinterface

// ===== rtl/bru_out_if.sv =====
// Result channel of the branch resolve unit: valid/ready handshake and the
// fields of one resolved branch. No dependencies.
`timescale 1ns / 1ps

interface bru_out_if;
  logic        valid;
  logic        ready;
  logic        taken;
  logic [31:0] next_pc;
  logic        table_read;
  logic        write_valid;
  logic [31:0] write_value;
  logic [3:0]  flags_out;

  modport source (
    output valid, taken, next_pc, table_read, write_valid, write_value, flags_out,
    input  ready
  );

  modport sink (
    input  valid, taken, next_pc, table_read, write_valid, write_value, flags_out,
    output ready
  );
endinterface

// ===== rtl/bru_exec.sv =====
// Combinational execute logic of the branch resolve unit: resolves one request
// against the current flags. Depends on bru_pkg.
`timescale 1ns / 1ps

module bru_exec (
  input  bru_pkg::req_t   req_i,
  input  bru_pkg::flags_t flags_i,
  output bru_pkg::res_t   res_o
);

  logic [31:0] mask;
  logic [31:0] sbit;
  logic [31:0] op_a, op_b, op_c;
  logic [31:0] sum, diff;
  logic [31:0] pc_in, pc_out;
  logic        acb_n, acb_z, acb_v, acb_br;
  logic        cas_n, cas_z, cas_c, cas_in;
  logic        cond_hit;
  logic        fn, fz, fv, fc;

  // Signed compare of values held within the width marked by sbit.
  function automatic logic lt_signed(logic [31:0] x, logic [31:0] y, logic [31:0] sb);
    return (x ^ sb) < (y ^ sb);
  endfunction

  always_comb begin
    unique case (req_i.size)
      bru_pkg::SZ_BYTE: begin
        mask = 32'h0000_00FF;
        sbit = 32'h0000_0080;
      end
      bru_pkg::SZ_WORD: begin
        mask = 32'h0000_FFFF;
        sbit = 32'h0000_8000;
      end
      default: begin
        mask = 32'hFFFF_FFFF;
        sbit = 32'h8000_0000;
      end
    endcase
  end

  assign op_a = req_i.operand_a & mask;
  assign op_b = req_i.operand_b & mask;
  assign op_c = req_i.operand_c & mask;

  // Add-compare-branch: index (c) plus addend (b) against limit (a).
  assign sum    = (op_c + op_b) & mask;
  assign acb_n  = |(sum & sbit);
  assign acb_z  = (sum == 32'd0);
  assign acb_v  = |(~(op_c ^ op_b) & (op_c ^ sum) & sbit);
  assign acb_br = (|(op_b & sbit)) ? !lt_signed(sum, op_a, sbit)
                                   : !lt_signed(op_a, sum, sbit);

  // Case dispatch: selector (a) minus base (b) against limit (c).
  assign diff   = (op_a - op_b) & mask;
  assign cas_n  = lt_signed(diff, op_c, sbit);
  assign cas_z  = (diff == op_c);
  assign cas_c  = (diff < op_c);
  assign cas_in = cas_c | cas_z;
  assign pc_in  = req_i.table_pc + {diff[30:0], 1'b0};
  assign pc_out = req_i.table_pc + {op_c[30:0], 1'b0} + 32'd2;

  assign fn = flags_i[bru_pkg::FLAG_N];
  assign fz = flags_i[bru_pkg::FLAG_Z];
  assign fv = flags_i[bru_pkg::FLAG_V];
  assign fc = flags_i[bru_pkg::FLAG_C];

  always_comb begin
    unique case (req_i.condition)
      bru_pkg::CC_NE:   cond_hit = !fz;
      bru_pkg::CC_EQ:   cond_hit = fz;
      bru_pkg::CC_GT:   cond_hit = !(fn | fz);
      bru_pkg::CC_LE:   cond_hit = fn | fz;
      bru_pkg::CC_GE:   cond_hit = !fn;
      bru_pkg::CC_LT:   cond_hit = fn;
      bru_pkg::CC_GTU:  cond_hit = !(fc | fz);
      bru_pkg::CC_LEQU: cond_hit = fc | fz;
      bru_pkg::CC_VC:   cond_hit = !fv;
      bru_pkg::CC_VS:   cond_hit = fv;
      bru_pkg::CC_GEQU: cond_hit = !fc;
      bru_pkg::CC_CS:   cond_hit = fc;
      bru_pkg::CC_LBS:  cond_hit = req_i.operand_a[0];
      bru_pkg::CC_LBC:  cond_hit = !req_i.operand_a[0];
      default:          cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    res_o = '0;
    unique case (req_i.operation)
      bru_pkg::OP_ACB: begin
        res_o.taken       = acb_br;
        res_o.next_pc     = req_i.branch_target;
        res_o.write_valid = 1'b1;
        res_o.write_value = sum;
        res_o.flags_out   = {acb_n, acb_z, acb_v, fc};
      end
      bru_pkg::OP_CASE: begin
        res_o.taken      = 1'b1;
        res_o.table_read = cas_in;
        res_o.next_pc    = cas_in ? pc_in : pc_out;
        res_o.flags_out  = {cas_n, cas_z, 1'b0, cas_c};
      end
      bru_pkg::OP_BCC: begin
        res_o.taken     = cond_hit;
        res_o.next_pc   = req_i.branch_target;
        res_o.flags_out = flags_i;
      end
      default: begin
        res_o.flags_out = flags_i;
      end
    endcase
  end

endmodule

// ===== rtl/branch_resolve_unit.sv =====
// Top level of the branch resolve unit: input register, execute logic, result
// register and the condition flag register. Depends on bru_pkg, bru_in_if,
// bru_out_if and bru_exec.
`timescale 1ns / 1ps

// The unit resolves one branch instruction per transfer: add-compare-branch,
// case dispatch or a conditional branch on the N, Z, V and C flags or on the
// low bit of a longword. It sustains one transfer per clock cycle while the
// result side is not stalled. Each instruction is held in the input
// register and then moves to the result register, which offers its result.
// The execute logic reads the flag register and writes it in the same cycle
// that an instruction moves from the input register to the result register,
// so every instruction sees the flags left by the one before it with no extra
// delay. Both registers hold their contents while the downstream side is
// stalled, and a new input transfer is taken whenever the input register is
// empty or moving on. After reset all flags are cleared and both registers
// are empty.
module branch_resolve_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  bru_in_if.sink    in_i,
  bru_out_if.source out_o
);

  bru_pkg::req_t   req_q;
  logic            req_valid_q;
  bru_pkg::res_t   res_d, res_q;
  logic            res_valid_q;
  bru_pkg::flags_t flags_q;

  logic res_free;
  logic req_move;
  logic in_xfer;

  // The result register can take a new entry when it is empty or being
  // drained this cycle; the input register empties when its entry moves on.
  assign res_free = !res_valid_q || out_o.ready;
  assign req_move = req_valid_q && res_free;
  assign in_xfer  = in_i.valid && in_i.ready;

  assign in_i.ready = !req_valid_q || res_free;

  bru_exec u_exec (
    .req_i   (req_q),
    .flags_i (flags_q),
    .res_o   (res_d)
  );

  // Control state and flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      if (in_xfer) begin
        req_valid_q <= 1'b1;
      end else if (req_move) begin
        req_valid_q <= 1'b0;
      end
      if (req_move) begin
        res_valid_q <= 1'b1;
        flags_q     <= res_d.flags_out;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q.operation     <= in_i.operation;
      req_q.size          <= in_i.size;
      req_q.condition     <= in_i.condition;
      req_q.operand_a     <= in_i.operand_a;
      req_q.operand_b     <= in_i.operand_b;
      req_q.operand_c     <= in_i.operand_c;
      req_q.table_pc      <= in_i.table_pc;
      req_q.branch_target <= in_i.branch_target;
    end
    if (req_move) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.taken       = res_q.taken;
  assign out_o.next_pc     = res_q.next_pc;
  assign out_o.table_read  = res_q.table_read;
  assign out_o.write_valid = res_q.write_valid;
  assign out_o.write_value = res_q.write_value;
  assign out_o.flags_out   = res_q.flags_out;

endmodule

// ===== sim/branch_resolve_unit_test.sv =====
// Self-checking testbench for branch_resolve_unit: directed and random branch
// instructions with random idling on both channels, checked by a scoreboard.
// Depends on bru_pkg, bru_in_if, bru_out_if and the branch_resolve_unit RTL.
`timescale 1ns / 1ps

module branch_resolve_unit_test;

  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned MAX_IDLE     = 12;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Scoreboard: keeps its own copy of the N, Z, V and C flags, predicts the
  // result of every accepted instruction and compares results in order.
  class branch_scoreboard;
    bru_pkg::flags_t flags;
    bru_pkg::res_t   pending_results[$];
    int unsigned     failures;

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Signed less-than of two values whose sign bit is sign_bit.
    function logic signed_below(logic [31:0] x, logic [31:0] y, logic [31:0] sign_bit);
      return (x ^ sign_bit) < (y ^ sign_bit);
    endfunction

    function logic condition_met(logic [3:0] cond, logic [31:0] word);
      logic n, z, v, c;
      n = flags[bru_pkg::FLAG_N];
      z = flags[bru_pkg::FLAG_Z];
      v = flags[bru_pkg::FLAG_V];
      c = flags[bru_pkg::FLAG_C];
      case (cond)
        bru_pkg::CC_NE:   return !z;
        bru_pkg::CC_EQ:   return z;
        bru_pkg::CC_GT:   return !(n || z);
        bru_pkg::CC_LE:   return n || z;
        bru_pkg::CC_GE:   return !n;
        bru_pkg::CC_LT:   return n;
        bru_pkg::CC_GTU:  return !(c || z);
        bru_pkg::CC_LEQU: return c || z;
        bru_pkg::CC_VC:   return !v;
        bru_pkg::CC_VS:   return v;
        bru_pkg::CC_GEQU: return !c;
        bru_pkg::CC_CS:   return c;
        bru_pkg::CC_LBS:  return word[0];
        bru_pkg::CC_LBC:  return !word[0];
        default:          return 1'b0;
      endcase
    endfunction

    // Works out the resolved branch and updates the flag copy.
    function bru_pkg::res_t resolve_branch(bru_pkg::req_t r);
      logic [31:0]   mask, sign_bit, loop_limit, addend, count, sum;
      logic [31:0]   selector, base, bound, offset;
      bru_pkg::res_t o;
      o = '0;
      case (r.size)
        bru_pkg::SZ_BYTE: mask = 32'h0000_00FF;
        bru_pkg::SZ_WORD: mask = 32'h0000_FFFF;
        default:          mask = 32'hFFFF_FFFF;
      endcase
      sign_bit = (mask >> 1) + 32'd1;
      case (r.operation)
        bru_pkg::OP_ACB: begin
          loop_limit = r.operand_a & mask;
          addend     = r.operand_b & mask;
          count      = r.operand_c & mask;
          sum        = (count + addend) & mask;
          // C is kept; N, Z and V follow the sum.
          flags[bru_pkg::FLAG_N] = (sum & sign_bit) != 0;
          flags[bru_pkg::FLAG_Z] = sum == 0;
          flags[bru_pkg::FLAG_V] = ((~(count ^ addend)) & (count ^ sum) & sign_bit) != 0;
          if ((addend & sign_bit) != 0)
            o.taken = !signed_below(sum, loop_limit, sign_bit);
          else
            o.taken = !signed_below(loop_limit, sum, sign_bit);
          o.next_pc     = r.branch_target;
          o.write_valid = 1'b1;
          o.write_value = sum;
        end
        bru_pkg::OP_CASE: begin
          selector = r.operand_a & mask;
          base     = r.operand_b & mask;
          bound    = r.operand_c & mask;
          offset   = (selector - base) & mask;
          flags[bru_pkg::FLAG_N] = signed_below(offset, bound, sign_bit);
          flags[bru_pkg::FLAG_Z] = offset == bound;
          flags[bru_pkg::FLAG_V] = 1'b0;
          flags[bru_pkg::FLAG_C] = offset < bound;
          o.taken = 1'b1;
          if (offset <= bound) begin
            o.table_read = 1'b1;
            o.next_pc    = r.table_pc + (offset << 1);
          end else begin
            o.next_pc = r.table_pc + 32'd2 + (bound << 1);
          end
        end
        bru_pkg::OP_BCC: begin
          o.taken   = condition_met(r.condition, r.operand_a);
          o.next_pc = r.branch_target;
        end
        default: ;
      endcase
      o.flags_out = flags;
      return o;
    endfunction

    function void note_instruction(bru_pkg::req_t r);
      pending_results.push_back(resolve_branch(r));
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(bru_pkg::res_t got);
      bru_pkg::res_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer with no instruction outstanding");
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("taken", 32'(want.taken), 32'(got.taken));
      compare_field("next_pc", want.next_pc, got.next_pc);
      compare_field("table_read", 32'(want.table_read), 32'(got.table_read));
      compare_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
      compare_field("write_value", want.write_value, got.write_value);
      compare_field("flags_out", 32'(want.flags_out), 32'(got.flags_out));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bru_in_if  in_ch ();
  bru_out_if out_ch ();

  branch_resolve_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  branch_scoreboard branch_sb;
  int unsigned      cycle_count;
  // When set, the side in question runs without idling for a stretch.
  logic             source_calm;
  logic             sink_calm;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Both handshakes are sampled at the clock edge in one process, so an
  // instruction is always noted before any later result is checked.
  always @(posedge clk_i) begin
    bru_pkg::req_t seen_req;
    bru_pkg::res_t seen_res;
    cycle_count <= cycle_count + 1;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      seen_req = '{operation: in_ch.operation, size: in_ch.size,
                   condition: in_ch.condition, operand_a: in_ch.operand_a,
                   operand_b: in_ch.operand_b, operand_c: in_ch.operand_c,
                   table_pc: in_ch.table_pc, branch_target: in_ch.branch_target};
      branch_sb.note_instruction(seen_req);
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      seen_res = '{taken: out_ch.taken, next_pc: out_ch.next_pc,
                   table_read: out_ch.table_read, write_valid: out_ch.write_valid,
                   write_value: out_ch.write_value, flags_out: out_ch.flags_out};
      branch_sb.check_result(seen_res);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  // Result side: stalls a random number of cycles before each transfer, with
  // stretches of no stalling at all.
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken_count;
    taken_count = 0;
    sink_calm = 1'b0;
    out_ch.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (taken_count % 40 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      stall = sink_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      taken_count++;
    end
  end

  // Offers one instruction after a random gap and waits for its transfer.
  // Valid stays high when the next instruction follows with no gap.
  task automatic send_instruction(input bru_pkg::req_t r);
    int unsigned gap;
    gap = source_calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= r.operation;
    in_ch.size          <= r.size;
    in_ch.condition     <= r.condition;
    in_ch.operand_a     <= r.operand_a;
    in_ch.operand_b     <= r.operand_b;
    in_ch.operand_c     <= r.operand_c;
    in_ch.table_pc      <= r.table_pc;
    in_ch.branch_target <= r.branch_target;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Holds the input side idle until every outstanding result has come back.
  // The first edge lets the last transfer reach the scoreboard.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (branch_sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic bru_pkg::req_t make_instruction(logic [1:0] op, logic [1:0] sz,
                                                     logic [3:0] cond, logic [31:0] a,
                                                     logic [31:0] b, logic [31:0] c,
                                                     logic [31:0] tpc,
                                                     logic [31:0] target);
    return '{operation: op, size: sz, condition: cond, operand_a: a, operand_b: b,
             operand_c: c, table_pc: tpc, branch_target: target};
  endfunction

  // Replaces the bits used at the operand size and keeps the rest as noise.
  function automatic logic [31:0] at_size(logic [31:0] raw, logic [31:0] value,
                                          logic [31:0] mask);
    return (raw & ~mask) | (value & mask);
  endfunction

  // Most add-compare items look like loop steps near their limit and most case
  // items land in or just beyond a small table; the rest is plain noise.
  function automatic bru_pkg::req_t random_instruction();
    bru_pkg::req_t r;
    int unsigned   pick;
    logic [31:0]   mask, step, lim;
    pick = $urandom_range(0, 99);
    if (pick < 35)      r.operation = bru_pkg::OP_ACB;
    else if (pick < 65) r.operation = bru_pkg::OP_CASE;
    else if (pick < 95) r.operation = bru_pkg::OP_BCC;
    else                r.operation = bru_pkg::OP_NONE;
    r.size          = 2'($urandom_range(0, 3));
    r.condition     = 4'($urandom_range(0, 15));
    r.operand_a     = $urandom;
    r.operand_b     = $urandom;
    r.operand_c     = $urandom;
    r.table_pc      = $urandom;
    r.branch_target = $urandom;
    case (r.size)
      bru_pkg::SZ_BYTE: mask = 32'h0000_00FF;
      bru_pkg::SZ_WORD: mask = 32'h0000_FFFF;
      default:          mask = 32'hFFFF_FFFF;
    endcase
    if ($urandom_range(0, 3) != 0) begin
      case (r.operation)
        bru_pkg::OP_ACB: begin
          step = $urandom_range(1, 3);
          if ($urandom_range(0, 1) != 0) step = -step;
          lim  = $urandom_range(0, 1) != 0 ? r.operand_a : $urandom_range(0, 20);
          r.operand_a = at_size(r.operand_a, lim, mask);
          r.operand_b = at_size(r.operand_b, step, mask);
          r.operand_c = at_size(r.operand_c,
                                lim - step + 32'($urandom_range(0, 4)) - 32'd2, mask);
        end
        bru_pkg::OP_CASE: begin
          lim = $urandom_range(0, 8);
          r.operand_c = at_size(r.operand_c, lim, mask);
          r.operand_a = at_size(r.operand_a,
                                r.operand_b + 32'($urandom_range(0, lim + 2)), mask);
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  initial begin : stimulus
    rst_ni <= 1'b0;
    source_calm = 1'b0;
    branch_sb = new;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= bru_pkg::OP_NONE;
    in_ch.size          <= bru_pkg::SZ_BYTE;
    in_ch.condition     <= bru_pkg::CC_NE;
    in_ch.operand_a     <= '0;
    in_ch.operand_b     <= '0;
    in_ch.operand_c     <= '0;
    in_ch.table_pc      <= '0;
    in_ch.branch_target <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Add-compare-branch: signed overflow at byte size with noise in the upper
    // bits, a negative addend reaching zero, longword extremes, and size code
    // three behaving as longword.
    send_instruction(make_instruction(bru_pkg::OP_ACB, bru_pkg::SZ_BYTE, bru_pkg::CC_NE,
                                      32'hFFFF_FF00, 32'hABCD_EF01, 32'h1234_567F,
                                      32'h0, 32'h0000_1000));
    send_instruction(make_instruction(bru_pkg::OP_ACB, bru_pkg::SZ_WORD, bru_pkg::CC_NE,
                                      32'h0, 32'h0000_FFFF, 32'h0000_0001, 32'h0,
                                      32'hFFFF_FFFF));
    send_instruction(make_instruction(bru_pkg::OP_ACB, bru_pkg::SZ_LONG, bru_pkg::CC_NE,
                                      32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'h0, 32'h8000_0000));
    send_instruction(make_instruction(bru_pkg::OP_ACB, bru_pkg::SZ_LONG, bru_pkg::CC_NE,
                                      32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF,
                                      32'h0, 32'h7FFF_FFFE));
    send_instruction(make_instruction(bru_pkg::OP_ACB, bru_pkg::SZ_RSVD, bru_pkg::CC_NE,
                                      32'd5, 32'd1, 32'd5, 32'h0, 32'h0000_0040));

    // Case dispatch: inside the table, at its last entry, a selector below the
    // base, the widest limit with the table address wrapping, and a byte
    // selector past the table with the skip address wrapping.
    send_instruction(make_instruction(bru_pkg::OP_CASE, bru_pkg::SZ_BYTE, bru_pkg::CC_NE,
                                      32'hFFFF_FF05, 32'h0000_0003, 32'h0000_0004,
                                      32'h0000_2000, 32'h0));
    send_instruction(make_instruction(bru_pkg::OP_CASE, bru_pkg::SZ_WORD, bru_pkg::CC_NE,
                                      32'h0000_1000, 32'h0000_0FFF, 32'h0000_0001,
                                      32'h0000_3000, 32'h0));
    send_instruction(make_instruction(bru_pkg::OP_CASE, bru_pkg::SZ_LONG, bru_pkg::CC_NE,
                                      32'h0, 32'h1, 32'h10, 32'h0000_4000, 32'h0));
    send_instruction(make_instruction(bru_pkg::OP_CASE, bru_pkg::SZ_RSVD, bru_pkg::CC_NE,
                                      32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                                      32'hFFFF_FFF0, 32'h0));
    send_instruction(make_instruction(bru_pkg::OP_CASE, bru_pkg::SZ_BYTE, bru_pkg::CC_NE,
                                      32'h0000_0080, 32'h0, 32'h0000_007F,
                                      32'hFFFF_FF00, 32'h0));

    // Every condition code, the two undefined ones included, with the low bit
    // of the tested longword alternating; then an undefined operation.
    for (int cc = 0; cc < 16; cc++)
      send_instruction(make_instruction(bru_pkg::OP_BCC, bru_pkg::SZ_BYTE, 4'(cc),
                                        {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'(cc)},
                                        32'h0, 32'h0, 32'h0, 32'hC000_0000 + 32'(cc)));
    send_instruction(make_instruction(bru_pkg::OP_NONE, bru_pkg::SZ_LONG, bru_pkg::CC_EQ,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF));

    // The input side stops until the pipeline is empty, here and halfway
    // through the random part.
    drain_results();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) source_calm = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) drain_results();
      send_instruction(random_instruction());
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (branch_sb.failures == 0 && branch_sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bru_pkg.sv
rtl/bru_in_if.sv
rtl/bru_out_if.sv
rtl/bru_exec.sv
rtl/branch_resolve_unit.sv
sim/branch_resolve_unit_test.sv
